FILE: rtl/lot_pkg.sv
// ----------------------------------------------------------------------------
// lot_pkg
// Shared types and constants for the LRU object translation block: field
// widths, sequencer states and the beats to and from the victim scanner.
// ----------------------------------------------------------------------------
package lot_pkg;

    localparam int ID_FIELD_W   = 3;
    localparam int SLOT_FIELD_W = 2;
    localparam int COORD_W      = 32;
    localparam int ENTRY_W      = 2 * COORD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_VICTIM,
        S_EVICT_RD,
        S_WB,
        S_LOAD,
        S_HIT_SLOT,
        S_HIT_RD
    } t_state;

    typedef struct packed {
        logic start;
        logic wr_en;
    } t_scan_req;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_rsp;

endpackage

FILE: rtl/lot_victim_scan.sv
// ----------------------------------------------------------------------------
// lot_victim_scan
// Holds the per-object access timestamps and walks them one entry a cycle,
// keeping the mapped object with the oldest timestamp (lowest id on ties).
// ----------------------------------------------------------------------------
module lot_victim_scan #(
    parameter int VIRTUAL_OBJECTS = 8,
    parameter int TIME_BITS       = 32,
    parameter int ID_W            = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lot_pkg::t_scan_req         i_req,
    input  logic [ID_W-1:0]            i_wr_id,
    input  logic [TIME_BITS-1:0]       i_wr_time,
    input  logic [VIRTUAL_OBJECTS-1:0] i_valid,
    output lot_pkg::t_scan_rsp         o_rsp,
    output logic [ID_W-1:0]            o_victim
);

    localparam logic [ID_W-1:0] LAST_ID = ID_W'(VIRTUAL_OBJECTS - 1);

    logic [TIME_BITS-1:0]       r_ts_mem [VIRTUAL_OBJECTS];
    logic [VIRTUAL_OBJECTS-1:0] r_ts_ok;
    logic [TIME_BITS-1:0]       r_ts_q;
    logic                       r_ok_q;
    logic [ID_W-1:0]            r_scan;
    logic                       r_busy;
    logic                       r_cmp_vld;
    logic [ID_W-1:0]            r_cmp_idx;
    logic [TIME_BITS-1:0]       r_best;
    logic                       r_found;
    logic [ID_W-1:0]            r_victim;
    logic                       r_done;
    logic [TIME_BITS-1:0]       ts_eff;
    logic                       take;

    assign ts_eff = r_ok_q ? r_ts_q : '0;
    assign take   = r_cmp_vld && i_valid[r_cmp_idx] && (!r_found || (ts_eff < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
            r_found   <= 1'b0;
            r_ts_ok   <= '0;
        end else begin
            r_done <= r_cmp_vld && (r_cmp_idx == LAST_ID);
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
            end else begin
                r_cmp_vld <= r_busy;
                if (r_busy && (r_scan == LAST_ID)) begin
                    r_busy <= 1'b0;
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (i_req.wr_en) begin
                r_ts_ok[i_wr_id] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts_q    <= r_ts_mem[r_scan];
        r_ok_q    <= r_ts_ok[r_scan];
        r_cmp_idx <= r_scan;
        if (i_req.start) begin
            r_scan <= '0;
        end else if (r_busy && (r_scan != LAST_ID)) begin
            r_scan <= r_scan + 1'b1;
        end
        if (take && !i_req.start) begin
            r_best   <= ts_eff;
            r_victim <= r_cmp_idx;
        end
        if (i_req.wr_en) begin
            r_ts_mem[i_wr_id] <= i_wr_time;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.found = r_found;
    assign o_victim    = r_victim;

endmodule

FILE: rtl/lru_object_translation.sv
// ----------------------------------------------------------------------------
// lru_object_translation
// Maps virtual objects onto physical slots with least-recently-used
// replacement, swapping object data with a backing store on a fault.
// ----------------------------------------------------------------------------
// Sequence: a hit runs S_CHECK, S_HIT_SLOT, S_HIT_RD; a fault runs S_CHECK,
// S_SCAN, S_VICTIM, S_EVICT_RD and S_WB when a victim is found, and S_LOAD.
// S_SCAN waits on the scan: one entry a cycle, through a single compare unit.
// Throughput: one item at a time; busy falls in the cycle o_valid is high, so
// the next item may be taken then. Each result is shown for one cycle only.
// Reset: synchronous; objects 0..PHYSICAL_SLOTS-1 sit in their own slots and
// all data, timestamps and the use counter read as zero. No clearing pass.
module lru_object_translation #(
    parameter int VIRTUAL_OBJECTS = 8,
    parameter int PHYSICAL_SLOTS  = 4,
    parameter int TIME_BITS       = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    input  logic        [lot_pkg::ID_FIELD_W-1:0]  i_virtual_id,
    input  logic signed [lot_pkg::COORD_W-1:0]     i_new_x,
    input  logic signed [lot_pkg::COORD_W-1:0]     i_new_y,
    output logic                                   busy,
    output logic                                   o_valid,
    output logic                                   o_hit,
    output logic        [lot_pkg::SLOT_FIELD_W-1:0] o_slot,
    output logic                                   o_evicted_valid,
    output logic        [lot_pkg::ID_FIELD_W-1:0]  o_evicted_id,
    output logic signed [lot_pkg::COORD_W-1:0]     o_old_x,
    output logic signed [lot_pkg::COORD_W-1:0]     o_old_y
);

    localparam int ID_W         = $clog2(VIRTUAL_OBJECTS);
    localparam int SLOT_W       = (PHYSICAL_SLOTS > 1) ? $clog2(PHYSICAL_SLOTS) : 1;
    localparam int N_MAPPED     = (PHYSICAL_SLOTS < VIRTUAL_OBJECTS) ?
                                  PHYSICAL_SLOTS : VIRTUAL_OBJECTS;
    localparam int RED_STEPS    = ((1 << lot_pkg::ID_FIELD_W) - 1) / VIRTUAL_OBJECTS + 1;
    localparam logic [7:0] VO_8 = 8'(VIRTUAL_OBJECTS);

    function automatic logic [ID_W-1:0] f_reduce_id(input logic [lot_pkg::ID_FIELD_W-1:0] id);
        logic [7:0] v;
        v = 8'(id);
        for (int k = 0; k < RED_STEPS; k++) begin
            if (v >= VO_8) begin
                v = v - VO_8;
            end
        end
        return ID_W'(v);
    endfunction

    lot_pkg::t_state r_state, n_state;

    logic [ID_W-1:0]                r_id;
    logic [lot_pkg::COORD_W-1:0]    r_new_x;
    logic [lot_pkg::COORD_W-1:0]    r_new_y;
    logic [VIRTUAL_OBJECTS-1:0]     r_valid;
    logic [TIME_BITS-1:0]           r_counter;
    logic [TIME_BITS-1:0]           n_counter;
    logic [SLOT_W-1:0]              r_slot;
    logic                           r_ev_valid;
    logic [ID_W-1:0]                r_ev_id;

    logic [SLOT_W-1:0]              r_map_mem [VIRTUAL_OBJECTS];
    logic [VIRTUAL_OBJECTS-1:0]     r_map_ok;
    logic [SLOT_W-1:0]              r_map_q;
    logic                           r_map_okq;
    logic [ID_W-1:0]                r_map_idx;

    logic [lot_pkg::ENTRY_W-1:0]    r_slot_mem [PHYSICAL_SLOTS];
    logic [PHYSICAL_SLOTS-1:0]      r_slot_ok;
    logic [lot_pkg::ENTRY_W-1:0]    r_slot_q;
    logic                           r_slot_okq;
    logic [lot_pkg::ENTRY_W-1:0]    slot_rd;

    logic [lot_pkg::ENTRY_W-1:0]    r_back_mem [VIRTUAL_OBJECTS];
    logic [VIRTUAL_OBJECTS-1:0]     r_back_ok;
    logic [lot_pkg::ENTRY_W-1:0]    r_back_q;
    logic                           r_back_okq;

    logic                           r_out_valid;
    logic                           r_out_hit;
    logic [lot_pkg::SLOT_FIELD_W-1:0] r_out_slot;
    logic                           r_out_ev_valid;
    logic [lot_pkg::ID_FIELD_W-1:0] r_out_ev_id;
    logic [lot_pkg::ENTRY_W-1:0]    r_out_old;

    lot_pkg::t_scan_req             scan_req;
    lot_pkg::t_scan_rsp             scan_rsp;
    logic [ID_W-1:0]                scan_victim;

    logic [ID_W-1:0]                map_raddr;
    logic [SLOT_W-1:0]              ms_slot;
    logic                           accept;
    logic                           take_slot;
    logic                           clear_slot;
    logic                           wb_en;
    logic                           finish_hit;
    logic                           finish_miss;
    logic                           finish;

    assign ms_slot   = r_map_okq ? r_map_q : SLOT_W'(r_map_idx);
    assign slot_rd   = r_slot_okq ? r_slot_q : '0;
    assign n_counter = r_counter + 1'b1;
    assign finish    = finish_hit || finish_miss;
    assign busy      = (r_state != lot_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lot_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        map_raddr   = r_id;
        scan_req    = '0;
        accept      = 1'b0;
        take_slot   = 1'b0;
        clear_slot  = 1'b0;
        wb_en       = 1'b0;
        finish_hit  = 1'b0;
        finish_miss = 1'b0;
        case (r_state)
            lot_pkg::S_IDLE: begin
                if (start) begin
                    accept  = 1'b1;
                    n_state = lot_pkg::S_CHECK;
                end
            end
            lot_pkg::S_CHECK: begin
                if (r_valid[r_id]) begin
                    n_state = lot_pkg::S_HIT_SLOT;
                end else begin
                    scan_req.start = 1'b1;
                    n_state        = lot_pkg::S_SCAN;
                end
            end
            lot_pkg::S_SCAN: begin
                if (scan_rsp.done) begin
                    n_state = lot_pkg::S_VICTIM;
                end
            end
            lot_pkg::S_VICTIM: begin
                map_raddr = scan_victim;
                if (scan_rsp.found) begin
                    n_state = lot_pkg::S_EVICT_RD;
                end else begin
                    clear_slot = 1'b1;
                    n_state    = lot_pkg::S_LOAD;
                end
            end
            lot_pkg::S_EVICT_RD: begin
                take_slot = 1'b1;
                n_state   = lot_pkg::S_WB;
            end
            lot_pkg::S_WB: begin
                wb_en   = 1'b1;
                n_state = lot_pkg::S_LOAD;
            end
            lot_pkg::S_LOAD: begin
                finish_miss    = 1'b1;
                scan_req.wr_en = 1'b1;
                n_state        = lot_pkg::S_IDLE;
            end
            lot_pkg::S_HIT_SLOT: begin
                take_slot = 1'b1;
                n_state   = lot_pkg::S_HIT_RD;
            end
            lot_pkg::S_HIT_RD: begin
                finish_hit     = 1'b1;
                scan_req.wr_en = 1'b1;
                n_state        = lot_pkg::S_IDLE;
            end
            default: begin
                n_state = lot_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VIRTUAL_OBJECTS; i++) begin
                r_valid[i] <= (i < PHYSICAL_SLOTS);
            end
            r_counter   <= '0;
            r_map_ok    <= '0;
            r_back_ok   <= '0;
            r_slot_ok   <= '0;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= finish;
            if (accept) begin
                r_ev_valid <= 1'b0;
            end
            if (wb_en) begin
                r_valid[scan_victim]   <= 1'b0;
                r_back_ok[scan_victim] <= 1'b1;
                r_ev_valid             <= 1'b1;
            end
            if (finish_miss) begin
                r_valid[r_id]  <= 1'b1;
                r_map_ok[r_id] <= 1'b1;
            end
            if (finish) begin
                r_counter         <= n_counter;
                r_slot_ok[r_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_map_q    <= r_map_mem[map_raddr];
        r_map_okq  <= r_map_ok[map_raddr];
        r_map_idx  <= map_raddr;
        r_slot_q   <= r_slot_mem[ms_slot];
        r_slot_okq <= r_slot_ok[ms_slot];
        r_back_q   <= r_back_mem[r_id];
        r_back_okq <= r_back_ok[r_id];
        if (accept) begin
            r_id    <= f_reduce_id(i_virtual_id);
            r_new_x <= i_new_x;
            r_new_y <= i_new_y;
            r_ev_id <= '0;
        end
        if (take_slot) begin
            r_slot <= ms_slot;
        end else if (clear_slot) begin
            r_slot <= '0;
        end
        if (wb_en) begin
            r_back_mem[scan_victim] <= slot_rd;
            r_ev_id                 <= scan_victim;
        end
        if (finish_miss) begin
            r_map_mem[r_id] <= r_slot;
        end
        if (finish) begin
            r_slot_mem[r_slot] <= {r_new_y, r_new_x};
            r_out_hit          <= finish_hit;
            r_out_slot         <= lot_pkg::SLOT_FIELD_W'(r_slot);
            r_out_ev_valid     <= r_ev_valid && finish_miss;
            r_out_ev_id        <= finish_miss ? lot_pkg::ID_FIELD_W'(r_ev_id) : '0;
            if (finish_hit) begin
                r_out_old <= slot_rd;
            end else begin
                r_out_old <= r_back_okq ? r_back_q : '0;
            end
        end
    end

    lot_victim_scan #(
        .VIRTUAL_OBJECTS (VIRTUAL_OBJECTS),
        .TIME_BITS       (TIME_BITS),
        .ID_W            (ID_W)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (scan_req),
        .i_wr_id   (r_id),
        .i_wr_time (n_counter),
        .i_valid   (r_valid),
        .o_rsp     (scan_rsp),
        .o_victim  (scan_victim)
    );

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_slot          = r_out_slot;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_id    = r_out_ev_id;
    assign o_old_x         = r_out_old[lot_pkg::COORD_W-1:0];
    assign o_old_y         = r_out_old[lot_pkg::ENTRY_W-1:lot_pkg::COORD_W];

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without an item in flight");

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (!o_evicted_valid && (o_evicted_id == '0)))
        else $error("hit reported an eviction");

    a_miss_evicts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> o_evicted_valid)
        else $error("fault without a victim");

    a_mapped_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lot_pkg::S_IDLE) |-> ($countones(r_valid) == N_MAPPED))
        else $error("mapped object count drifted");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lru_object_translation. A directed table walks the
// reset mapping, tie-broken eviction and the coordinate extremes, then about
// 750 random write accesses follow, biased towards small working sets. Every
// accepted beat runs through a local LRU translation model; each result strobe
// is compared field by field with the oldest expectation (table or model).
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OBJECTS      = 8;
    localparam int SLOTS        = 4;
    localparam int RANDOM_BEATS = 750;
    localparam int DIRECTED_N   = 20;
    localparam int SETTLE_CYCS  = 30;

    typedef struct packed {
        logic                               hit;
        logic [lot_pkg::SLOT_FIELD_W-1:0]   slot;
        logic                               ev_valid;
        logic [lot_pkg::ID_FIELD_W-1:0]     ev_id;
        logic signed [lot_pkg::COORD_W-1:0] old_x;
        logic signed [lot_pkg::COORD_W-1:0] old_y;
    } t_xlat;

    typedef struct packed {
        logic [lot_pkg::ID_FIELD_W-1:0]     id;
        logic signed [lot_pkg::COORD_W-1:0] x;
        logic signed [lot_pkg::COORD_W-1:0] y;
        logic                               typed;
        t_xlat                              res;
    } t_access_row;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n;
    logic                                   start;
    logic [lot_pkg::ID_FIELD_W-1:0]         i_virtual_id;
    logic signed [lot_pkg::COORD_W-1:0]     i_new_x;
    logic signed [lot_pkg::COORD_W-1:0]     i_new_y;
    logic                                   busy;
    logic                                   o_valid;
    logic                                   o_hit;
    logic [lot_pkg::SLOT_FIELD_W-1:0]       o_slot;
    logic                                   o_evicted_valid;
    logic [lot_pkg::ID_FIELD_W-1:0]         o_evicted_id;
    logic signed [lot_pkg::COORD_W-1:0]     o_old_x;
    logic signed [lot_pkg::COORD_W-1:0]     o_old_y;

    lru_object_translation u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_virtual_id    (i_virtual_id),
        .i_new_x         (i_new_x),
        .i_new_y         (i_new_y),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id),
        .o_old_x         (o_old_x),
        .o_old_y         (o_old_y)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // translation model state
    logic                               obj_mapped [OBJECTS];
    logic [lot_pkg::SLOT_FIELD_W-1:0]   obj_slot   [OBJECTS];
    logic [31:0]                        obj_stamp  [OBJECTS];
    logic [31:0]                        access_count;
    logic [lot_pkg::ENTRY_W-1:0]        slot_data  [SLOTS];
    logic [lot_pkg::ENTRY_W-1:0]        spill_data [OBJECTS];

    t_xlat       expected_xlats [$];
    t_access_row directed [DIRECTED_N];
    int          errors;
    int          beats_sent;
    int          hits_seen;
    int          faults_seen;
    int          evictions_seen;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic reset_model();
        for (int i = 0; i < OBJECTS; i++) begin
            obj_mapped[i] = (i < SLOTS);
            obj_slot[i]   = lot_pkg::SLOT_FIELD_W'(i % SLOTS);
            obj_stamp[i]  = '0;
            spill_data[i] = '0;
        end
        for (int i = 0; i < SLOTS; i++)
            slot_data[i] = '0;
        access_count = '0;
    endtask

    function automatic t_xlat translate_access(input logic [lot_pkg::ID_FIELD_W-1:0] id,
                                               input logic [31:0] x, input logic [31:0] y);
        t_xlat                              r;
        int                                 victim;
        bit                                 found;
        logic [31:0]                        oldest;
        logic [lot_pkg::SLOT_FIELD_W-1:0]   s;
        r          = '0;
        r.hit      = obj_mapped[id];
        s          = obj_slot[id];
        if (!r.hit) begin
            found  = 1'b0;
            oldest = '0;
            victim = 0;
            for (int i = 0; i < OBJECTS; i++) begin
                if (obj_mapped[i] && (!found || obj_stamp[i] < oldest)) begin
                    found  = 1'b1;
                    oldest = obj_stamp[i];
                    victim = i;
                end
            end
            s = '0;
            if (found) begin
                s                  = obj_slot[victim];
                spill_data[victim] = slot_data[s];
                obj_mapped[victim] = 1'b0;
                obj_stamp[victim]  = '0;
                r.ev_valid         = 1'b1;
                r.ev_id            = lot_pkg::ID_FIELD_W'(victim);
            end
            obj_mapped[id] = 1'b1;
            obj_slot[id]   = s;
            slot_data[s]   = spill_data[id];
        end
        r.slot         = s;
        r.old_x        = slot_data[s][31:0];
        r.old_y        = slot_data[s][63:32];
        slot_data[s]   = {y, x};
        access_count   = access_count + 32'd1;
        obj_stamp[id]  = access_count;
        return r;
    endfunction

    // entered and left at a falling edge; start stays high after the beat
    task automatic send_access(input int gap, input t_access_row row);
        t_xlat pred;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        = 1'b1;
        i_virtual_id = row.id;
        i_new_x      = row.x;
        i_new_y      = row.y;
        do @(posedge i_clk); while (busy);
        pred = translate_access(row.id, row.x, row.y);
        expected_xlats.push_back(row.typed ? row.res : pred);
        beats_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord();
        logic [31:0] v;
        case ($urandom_range(0, 11))
            0:       v = 32'h0000_0000;
            1:       v = 32'hffff_ffff;
            2:       v = 32'h7fff_ffff;
            3:       v = 32'h8000_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_xlat want;
        if (i_rst_n && o_valid) begin
            if (expected_xlats.size() == 0) begin
                report("unexpected result, hit", 32'(o_hit), 32'h0);
            end else begin
                want = expected_xlats.pop_front();
                if (o_hit !== want.hit)
                    report("hit", 32'(o_hit), 32'(want.hit));
                if (o_slot !== want.slot)
                    report("slot", 32'(o_slot), 32'(want.slot));
                if (o_evicted_valid !== want.ev_valid)
                    report("evicted_valid", 32'(o_evicted_valid), 32'(want.ev_valid));
                if (o_evicted_id !== want.ev_id)
                    report("evicted_id", 32'(o_evicted_id), 32'(want.ev_id));
                if (o_old_x !== want.old_x)
                    report("old_x", o_old_x, want.old_x);
                if (o_old_y !== want.old_y)
                    report("old_y", o_old_y, want.old_y);
            end
            if (o_hit === 1'b1)
                hits_seen++;
            else
                faults_seen++;
            if (o_evicted_valid === 1'b1)
                evictions_seen++;
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [lot_pkg::ID_FIELD_W-1:0] work_set [4];
        t_access_row                    row;
        int                             gap;

        errors         = 0;
        beats_sent     = 0;
        hits_seen      = 0;
        faults_seen    = 0;
        evictions_seen = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_virtual_id   = '0;
        i_new_x        = '0;
        i_new_y        = '0;
        reset_model();

        directed = '{
            '{3'd7, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1,
              '{1'b0, 2'd0, 1'b1, 3'd0, 32'sh0, 32'sh0}},
            '{3'd5, 32'shffff_ffff, 32'sh0, 1'b1,
              '{1'b0, 2'd1, 1'b1, 3'd1, 32'sh0, 32'sh0}},
            '{3'd2, 32'sh0, 32'shffff_ffff, 1'b1,
              '{1'b1, 2'd2, 1'b0, 3'd0, 32'sh0, 32'sh0}},
            '{3'd3, 32'sh1, 32'sh1, 1'b1,
              '{1'b1, 2'd3, 1'b0, 3'd0, 32'sh0, 32'sh0}},
            '{3'd7, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1,
              '{1'b1, 2'd0, 1'b0, 3'd0, 32'sh7fff_ffff, 32'sh8000_0000}},
            '{3'd5, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b1,
              '{1'b1, 2'd1, 1'b0, 3'd0, 32'shffff_ffff, 32'sh0}},
            '{3'd0, 32'shaaaa_aaaa, 32'sh5555_5555, 1'b0, '0},
            '{3'd1, 32'sh1234_5678, 32'shedcb_a988, 1'b0, '0},
            '{3'd4, 32'sh0, 32'sh0, 1'b0, '0},
            '{3'd6, 32'shffff_ffff, 32'shffff_ffff, 1'b0, '0},
            '{3'd7, 32'sh1, 32'shffff_ffff, 1'b0, '0},
            '{3'd0, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, '0},
            '{3'd2, 32'sh8000_0000, 32'sh8000_0000, 1'b0, '0},
            '{3'd5, 32'sh3, 32'sh4, 1'b0, '0},
            '{3'd3, 32'shffff_fffe, 32'sh2, 1'b0, '0},
            '{3'd6, 32'sh0f0f_0f0f, 32'shf0f0_f0f0, 1'b0, '0},
            '{3'd1, 32'sh0, 32'sh0, 1'b0, '0},
            '{3'd4, 32'shdead_beef, 32'sh1357_9bdf, 1'b0, '0},
            '{3'd7, 32'sh0, 32'sh0, 1'b0, '0},
            '{3'd2, 32'sh2a, 32'shffff_ffd6, 1'b0, '0}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int n = 0; n < DIRECTED_N; n++)
            send_access((n < 6) ? 0 : $urandom_range(0, 11), directed[n]);

        for (int k = 0; k < 4; k++)
            work_set[k] = lot_pkg::ID_FIELD_W'($urandom_range(0, OBJECTS - 1));

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 64 == 0) begin
                for (int k = 0; k < 4; k++)
                    work_set[k] = lot_pkg::ID_FIELD_W'($urandom_range(0, OBJECTS - 1));
            end
            // drain completely once, mid-run
            if (n == RANDOM_BEATS / 2) begin
                start = 1'b0;
                while (expected_xlats.size() != 0) @(negedge i_clk);
            end
            row       = '0;
            row.typed = 1'b0;
            if ($urandom_range(0, 9) < 6)
                row.id = work_set[$urandom_range(0, 3)];
            else
                row.id = lot_pkg::ID_FIELD_W'($urandom_range(0, OBJECTS - 1));
            row.x = pick_coord();
            row.y = pick_coord();
            gap   = ((n / 40) % 3 == 1) ? 0 : $urandom_range(0, 11);
            send_access(gap, row);
        end
        start = 1'b0;

        while (expected_xlats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCS) @(posedge i_clk);
        if (expected_xlats.size() != 0)
            report("results outstanding", 32'(expected_xlats.size()), 32'h0);

        $display("%0d access beats sent: %0d hits, %0d faults, %0d evictions observed",
                 beats_sent, hits_seen, faults_seen, evictions_seen);
        $display("directed reset mapping, tie-broken victims and coordinate extremes included");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
